/* design/tdq_pkg.sv */
// Shared types and constants for the timer deadline queue.
`default_nettype none
package tdq_pkg;
   localparam logic [1:0] FUNC_ADD   = 2'd0;
   localparam logic [1:0] FUNC_CLEAR = 2'd1;
   localparam logic [1:0] FUNC_TICK  = 2'd2;
   localparam logic [1:0] FUNC_NOP   = 2'd3;

   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_FULL        = 2'd1;
   localparam logic [1:0] ST_NOT_FOUND   = 2'd2;
   localparam logic [1:0] ST_NOTHING_DUE = 2'd3;

   // Controller to datapath commands.
   typedef struct packed {
      logic load;     // capture the request item
      logic scan_clr; // restart the slot scan
      logic scan_step;// examine one slot
      logic apply;    // perform the operation
      logic rescan;   // restart scan for the earliest deadline
      logic finish;   // capture the result item
   } cmd_type;

   // Datapath to controller status.
   typedef struct packed {
      logic scan_done;
   } sts_type;
endpackage
`default_nettype wire

/* design/tdq_ctrl.sv */
// Controller state machine of the timer deadline queue.
`default_nettype none
module tdq_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   output logic                  rsp_tvalid,
   input  wire logic             rsp_tready,
   output tdq_pkg::cmd_type      cmd,
   input  wire tdq_pkg::sts_type sts
);
   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_SCAN  = 6'b000010,
      S_APPLY = 6'b000100,
      S_MIN   = 6'b001000,
      S_FIN   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // Accept a new item in idle, or while the output waits unless that output is still held.
   assign req_tready = !reset &&
                       ((state_ff == S_IDLE) || (state_ff == S_OUT && rsp_tready));
   assign rsp_tvalid = (state_ff == S_OUT);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1; cmd.scan_clr = 1'b1; state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_APPLY;
         end
         S_APPLY: begin
            cmd.apply = 1'b1; cmd.rescan = 1'b1; state_in = S_MIN;
         end
         S_MIN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_done) state_in = S_FIN;
         end
         S_FIN: begin
            cmd.finish = 1'b1; state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               if (req_tvalid) begin
                  cmd.load = 1'b1; cmd.scan_clr = 1'b1; state_in = S_SCAN;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end
endmodule
`default_nettype wire

/* design/tdq_dpath.sv */
// Slot store, scan unit and result registers of the timer deadline queue.
`default_nettype none
module tdq_dpath #(
   parameter int TIMER_SLOTS = 16
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire tdq_pkg::cmd_type cmd,
   output tdq_pkg::sts_type      sts,
   input  wire logic [1:0]       in_func,
   input  wire logic [63:0]      in_now,
   input  wire logic [63:0]      in_delay,
   input  wire logic             in_repeat,
   input  wire logic [31:0]      in_clear_id,
   output logic [1:0]            out_status,
   output logic [31:0]           out_timer_id,
   output logic                  out_fired,
   output logic [63:0]           out_next_deadline,
   output logic                  out_has_pending
);
   localparam int IW = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
   localparam int CW = $clog2(TIMER_SLOTS + 1);

   logic [63:0] deadline_ff [TIMER_SLOTS];
   logic [31:0] entry_id_ff [TIMER_SLOTS];
   logic [63:0] interval_ff [TIMER_SLOTS];
   logic [TIMER_SLOTS-1:0] valid_ff;
   logic [31:0] id_counter_ff;

   logic [1:0]  func_ff;
   logic [63:0] now_ff, delay_ff;
   logic        repeat_ff;
   logic [31:0] clear_id_ff;

   // Scan state: free slot, clear match and earliest slot found so far.
   logic [CW-1:0] cnt_ff;
   logic          free_hit_ff, match_hit_ff, best_hit_ff;
   logic [IW-1:0] free_idx_ff, match_idx_ff, best_idx_ff;
   logic [63:0]   best_dl_ff;
   logic [31:0]   best_id_ff;

   logic [1:0]  status_ff;
   logic [31:0] tid_ff;
   logic        fired_ff;

   logic [IW-1:0] cur;
   logic          better;
   logic [64:0]   sum;
   logic [63:0]   addend, sat;

   assign cur = cnt_ff[IW-1:0];
   assign sts.scan_done = (cnt_ff == CW'(TIMER_SLOTS - 1));
   assign better = !best_hit_ff || deadline_ff[cur] < best_dl_ff ||
                   (deadline_ff[cur] == best_dl_ff && entry_id_ff[cur] < best_id_ff);

   assign addend = (func_ff == tdq_pkg::FUNC_ADD) ? delay_ff : interval_ff[best_idx_ff];
   assign sum = {1'b0, now_ff} + {1'b0, addend};
   assign sat = sum[64] ? '1 : sum[63:0];

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= in_func; now_ff <= in_now; delay_ff <= in_delay;
         repeat_ff <= in_repeat; clear_id_ff <= in_clear_id;
      end
      if (cmd.scan_clr || cmd.rescan) begin
         cnt_ff <= '0; free_hit_ff <= 1'b0; match_hit_ff <= 1'b0; best_hit_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         cnt_ff <= sts.scan_done ? cnt_ff : cnt_ff + 1'b1;
         if (!valid_ff[cur] && !free_hit_ff) begin
            free_hit_ff <= 1'b1; free_idx_ff <= cur;
         end
         if (valid_ff[cur] && entry_id_ff[cur] == clear_id_ff && !match_hit_ff) begin
            match_hit_ff <= 1'b1; match_idx_ff <= cur;
         end
         if (valid_ff[cur] && better) begin
            best_hit_ff <= 1'b1; best_idx_ff <= cur;
            best_dl_ff <= deadline_ff[cur]; best_id_ff <= entry_id_ff[cur];
         end
      end
      if (cmd.apply) begin
         status_ff <= tdq_pkg::ST_OK; tid_ff <= '0; fired_ff <= 1'b0;
         case (func_ff)
            tdq_pkg::FUNC_ADD: begin
               if (!free_hit_ff) begin
                  status_ff <= tdq_pkg::ST_FULL;
               end else begin
                  deadline_ff[free_idx_ff] <= sat;
                  entry_id_ff[free_idx_ff] <= id_counter_ff + 32'd1;
                  interval_ff[free_idx_ff] <= repeat_ff ? delay_ff : '0;
                  tid_ff <= id_counter_ff + 32'd1;
               end
            end
            tdq_pkg::FUNC_CLEAR: begin
               if (!match_hit_ff) status_ff <= tdq_pkg::ST_NOT_FOUND;
            end
            tdq_pkg::FUNC_TICK: begin
               if (!best_hit_ff || best_dl_ff > now_ff) begin
                  status_ff <= tdq_pkg::ST_NOTHING_DUE;
               end else begin
                  tid_ff <= best_id_ff; fired_ff <= 1'b1;
                  if (interval_ff[best_idx_ff] != '0) deadline_ff[best_idx_ff] <= sat;
               end
            end
            default: ;
         endcase
      end
      if (cmd.finish) begin
         out_status <= status_ff; out_timer_id <= tid_ff; out_fired <= fired_ff;
         out_next_deadline <= best_hit_ff ? best_dl_ff : '0;
         out_has_pending <= best_hit_ff;
      end
   end

   // Control state: valid bits and the id sequence.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0; id_counter_ff <= '0;
      end else if (cmd.apply) begin
         case (func_ff)
            tdq_pkg::FUNC_ADD: begin
               if (free_hit_ff) begin
                  valid_ff[free_idx_ff] <= 1'b1; id_counter_ff <= id_counter_ff + 32'd1;
               end
            end
            tdq_pkg::FUNC_CLEAR: begin
               if (match_hit_ff) valid_ff[match_idx_ff] <= 1'b0;
            end
            tdq_pkg::FUNC_TICK: begin
               if (best_hit_ff && best_dl_ff <= now_ff && interval_ff[best_idx_ff] == '0)
                  valid_ff[best_idx_ff] <= 1'b0;
            end
            default: ;
         endcase
      end
   end
endmodule
`default_nettype wire

/* design/timer_deadline_queue.sv */
// Top level of the timer deadline queue: controller plus datapath.
//
// Use: send one item on req_* (add, clear or tick); exactly one result
// item comes back on rsp_* with status, id, fired flag, the earliest pending
// deadline and a pending flag.
// Sequence: one slot is examined per cycle; after acceptance an item passes
// through a slot scan for free slot, clear match and earliest timer, an apply
// step, a second scan for the new earliest deadline, and a result capture.
// Items do not overlap: a new item is taken from idle, or in the same cycle
// the result of the last item is taken.
// Reset: all slots empty and the id sequence restarts, first id is 1.
// Stall: while rsp_tready is low the result holds and no new item enters.
`default_nettype none
module timer_deadline_queue #(
   parameter int TIMER_SLOTS = 16
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_tvalid,
   output logic              req_tready,
   input  wire logic [167:0] req_tdata,  // func[1:0], now[65:2], delay[129:66],
                                         // repeat_mode[130], clear_id[162:131], zero
   output logic              rsp_tvalid,
   input  wire logic         rsp_tready,
   output logic [103:0]      rsp_tdata   // status[1:0], result_id[33:2], fired[34],
                                         // next_deadline[98:35], has_pending[99], zero
);
   tdq_pkg::cmd_type cmd;
   tdq_pkg::sts_type sts;
   logic [1:0]  status;
   logic [31:0] result_id;
   logic        fired;
   logic [63:0] next_deadline;
   logic        has_pending;

   tdq_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .cmd(cmd), .sts(sts)
   );

   tdq_dpath #(.TIMER_SLOTS(TIMER_SLOTS)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .sts(sts),
      .in_func(req_tdata[1:0]), .in_now(req_tdata[65:2]),
      .in_delay(req_tdata[129:66]), .in_repeat(req_tdata[130]),
      .in_clear_id(req_tdata[162:131]),
      .out_status(status), .out_timer_id(result_id), .out_fired(fired),
      .out_next_deadline(next_deadline), .out_has_pending(has_pending)
   );

   assign rsp_tdata = {4'd0, has_pending, next_deadline, fired, result_id, status};
endmodule
`default_nettype wire
